FILE: src/sks_pkg.sv
// package for the sorted key binary search block
// holds word layouts, mode codes, fsm states, controller/datapath links and key canonicalization
// no dependencies
`default_nettype none

package sks_pkg;

    localparam int KEY_W   = 64;
    localparam int CHAR_W  = 8;
    localparam int NCHARS  = KEY_W / CHAR_W;
    localparam int IDX_W   = 16;
    localparam int PROBE_W = 5;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   match_index;
        logic [PROBE_W-1:0] probe_count;
        logic               overflow;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input word taken this cycle
        logic load_imm;   // load result of clear / append / empty search / unused mode
        logic probe;      // read table at window midpoint
        logic step;       // compare read key and narrow the window
        logic load_srch;  // load result of a finished search
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic table_empty;
        logic hit;
        logic last;       // miss and the narrowed window is empty
    } t_stat;

    // keep the first chars bytes and zero every byte after the first zero byte
    function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] k,
                                                   input int unsigned chars);
        logic [KEY_W-1:0]  res;
        logic [CHAR_W-1:0] b;
        logic              ended;
        res   = '0;
        ended = 1'b0;
        for (int i = 0; i < NCHARS; i++) begin
            b = k[KEY_W-1-CHAR_W*i -: CHAR_W];
            if (i >= chars || ended) begin
                b = '0;
            end
            if (b == '0) begin
                ended = 1'b1;
            end
            res[KEY_W-1-CHAR_W*i -: CHAR_W] = b;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/sks_ctrl.sv
// controller fsm for the sorted key binary search block
// sequences accept, probe and compare steps; owns the result valid flag; uses sks_pkg
`default_nettype none

module sks_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_mode,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire sks_pkg::t_stat i_stat,
    output sks_pkg::t_cmd      o_cmd
);
    import sks_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_ready;
    logic   accept;
    logic   is_search;

    // one word in flight; take the next once the result slot frees up
    assign in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept    = in_ready && i_in_valid;
    assign is_search = (i_mode == MODE_SEARCH) && !i_stat.table_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_search) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                n_state = ST_COMPARE;
            end
            ST_COMPARE: begin
                if (i_stat.hit || i_stat.last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_PROBE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept   = accept;
                o_cmd.load_imm = accept && !is_search;
            end
            ST_PROBE: begin
                o_cmd.probe = 1'b1;
            end
            ST_COMPARE: begin
                o_cmd.step      = 1'b1;
                o_cmd.load_srch = i_stat.hit || i_stat.last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_imm || o_cmd.load_srch) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: src/sks_dpath.sv
// datapath for the sorted key binary search block
// key table memory, entry count, search window, compare and result register; uses sks_pkg
`default_nettype none

module sks_dpath #(
    parameter int TABLE_DEPTH = 65536,
    parameter int KEY_CHARS   = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sks_pkg::t_cmd     i_cmd,
    input  wire sks_pkg::t_in_word i_in_word,
    output sks_pkg::t_stat         o_stat,
    output sks_pkg::t_out_word     o_out_word
);
    import sks_pkg::*;

    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int COUNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_EXT_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    logic [KEY_W-1:0]   r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]   r_rdata;
    logic [KEY_W-1:0]   r_target;
    logic [COUNT_W-1:0] r_count, n_count;
    // window is [r_lo, r_hi), upper end exclusive
    logic [COUNT_W-1:0] r_lo, n_lo;
    logic [COUNT_W-1:0] r_hi, n_hi;
    logic [COUNT_W-1:0] r_mid;
    logic [PROBE_W-1:0] r_probes, n_probes;
    t_out_word          r_out, n_out;

    logic [COUNT_W-1:0] span;
    logic [COUNT_W-1:0] mid;
    logic [COUNT_W-1:0] mid_inc;
    logic               full;
    logic               do_write;
    logic               hit;
    logic               less;
    logic               next_empty;
    logic [KEY_W-1:0]   canon_in;
    logic [IDX_EXT_W-1:0] count_ext;
    logic [IDX_EXT_W-1:0] mid_ext;
    t_out_word          imm_word;
    t_out_word          srch_word;

    assign full      = (r_count == COUNT_W'(TABLE_DEPTH));
    assign do_write  = i_cmd.accept && (i_in_word.mode == MODE_APPEND) && !full;
    assign canon_in  = canon_key(i_in_word.key, KEY_CHARS);

    assign span    = r_hi - r_lo - COUNT_W'(1);
    assign mid     = r_lo + (span >> 1);
    assign mid_inc = r_mid + COUNT_W'(1);

    assign hit  = (r_rdata == r_target);
    assign less = (r_target < r_rdata);
    assign next_empty = less ? (r_lo >= r_mid) : (mid_inc >= r_hi);

    assign count_ext = IDX_EXT_W'(r_count[ADDR_W-1:0]);
    assign mid_ext   = IDX_EXT_W'(r_mid[ADDR_W-1:0]);

    // table stores canonical keys so the compare path is a plain 64-bit compare
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_count[ADDR_W-1:0]] <= canon_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe) begin
            r_rdata <= r_mem[mid[ADDR_W-1:0]];
        end
    end

    always_comb begin
        imm_word = '0;
        if (i_in_word.mode == MODE_APPEND) begin
            if (full) begin
                imm_word.overflow = 1'b1;
            end else begin
                imm_word.match_index = count_ext[IDX_W-1:0];
            end
        end
    end

    always_comb begin
        srch_word             = '0;
        srch_word.found       = hit;
        srch_word.match_index = hit ? mid_ext[IDX_W-1:0] : '0;
        srch_word.probe_count = r_probes;
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.accept) begin
            case (i_in_word.mode)
                MODE_CLEAR: begin
                    n_count = '0;
                end
                MODE_APPEND: begin
                    if (!full) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_comb begin
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_probes = r_probes;
        if (i_cmd.accept) begin
            n_lo     = '0;
            n_hi     = r_count;
            n_probes = '0;
        end else if (i_cmd.probe) begin
            n_probes = r_probes + PROBE_W'(1);
        end else if (i_cmd.step) begin
            if (less) begin
                n_hi = r_mid;
            end else begin
                n_lo = mid_inc;
            end
        end
    end

    always_comb begin
        n_out = r_out;
        if (i_cmd.load_imm) begin
            n_out = imm_word;
        end else if (i_cmd.load_srch) begin
            n_out = srch_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_probes <= n_probes;
        r_out    <= n_out;
        if (i_cmd.accept) begin
            r_target <= canon_in;
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
    end

    assign o_stat.table_empty = (r_count == '0);
    assign o_stat.hit         = hit;
    assign o_stat.last        = !hit && next_empty;
    assign o_out_word         = r_out;

endmodule

`default_nettype wire

FILE: src/sorted_key_binary_search_top.sv
// sorted key binary search: a table of 8-character keys appended in order, searched by halving
// input word: mode 0 clears the table, 1 appends a key, 2 searches for a key
// output word: found, match_index, probe_count, overflow; exactly one per input word
// both channels are valid/ready; a word moves when valid and ready are high at a clock edge
// clear, append and unused-mode words, and searches of an empty table, give their result
// in the cycle after acceptance
// a search with P probes (at most clog2(TABLE_DEPTH)+1, 17 at 65536) gives its result
// once its last compare hits or empties the window, and holds the block until then;
// each probe is one read of the key table then one 64-bit compare
// one word is worked at a time; o_in_ready is high while idle and the result register
// is empty or being emptied, so a new word can enter in the cycle its predecessor's
// result is taken
// a stalled receiver holds the result in the output register and blocks further input
// reset (i_rst_n low, synchronous) empties the table and the result register; the table
// contents are not cleared and are only read below the entry count
// depends on sks_pkg, sks_ctrl and sks_dpath
`default_nettype none

module sorted_key_binary_search_top #(
    parameter int TABLE_DEPTH = 65536,
    parameter int KEY_CHARS   = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sks_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output sks_pkg::t_out_word      o_out_word
);
    import sks_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_in_word.mode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sks_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_stat     (stat),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire
